/* sv/fis_pkg.sv */
// ----------------------------------------------------------------------------
// fis_pkg: shared types and constants for the frame index sequencer
// Field widths, function codes, register indexes and the frame clip function.
// ----------------------------------------------------------------------------
`default_nettype none

package fis_pkg;

  localparam int MAX_FRAMES = 256;

  localparam int FUNC_W   = 2;
  localparam int TIME_W   = 32;
  localparam int IVAL_W   = 9;
  localparam int FRAME_W  = 8;
  localparam int POS_W    = 9;
  localparam int REPEAT_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INDEX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_SWITCH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NO_SKIP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE   = 3'd6;

  // saturate a non-negative position to the last legal frame
  function automatic logic [FRAME_W-1:0] clip_frame(input logic [10:0] v);
    logic [FRAME_W-1:0] f;
    if (32'(v) >= 32'(MAX_FRAMES)) begin
      f = FRAME_W'(MAX_FRAMES - 1);
    end else begin
      f = v[FRAME_W-1:0];
    end
    return f;
  endfunction

endpackage

`default_nettype wire

/* sv/fis_stream_if.sv */
// ----------------------------------------------------------------------------
// fis_stream_if: valid/ready channels of the frame index sequencer
// Request channel (function, time, index) and response channel (frames).
// ----------------------------------------------------------------------------
`default_nettype none

interface fis_req_if
  import fis_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TIME_W-1:0] time_ticks;
  logic [IVAL_W-1:0] index_value;

  modport source (output valid, func, time_ticks, index_value, input ready);
  modport sink   (input valid, func, time_ticks, index_value, output ready);
endinterface

interface fis_rsp_if
  import fis_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] shown_index;
  logic [FRAME_W-1:0] requested_index;
  logic               changed;

  modport source (output valid, shown_index, requested_index, changed, input ready);
  modport sink   (input valid, shown_index, requested_index, changed, output ready);
endinterface

`default_nettype wire

/* sv/fis_div.sv */
// ----------------------------------------------------------------------------
// fis_div: serial restoring divider
// 32-bit unsigned quotient and remainder, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fis_div
  import fis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic      [TIME_W-1:0] quotient,
  output logic      [TIME_W-1:0] remainder
);

  logic                      busy;
  logic [4:0]                count;
  logic [TIME_W-1:0]         rem;
  logic [TIME_W-1:0]         quo;
  logic [TIME_W-1:0]         dvs;
  logic [TIME_W:0]           shifted;
  logic [TIME_W+1:0]         diff;
  logic                      fits;

  always_comb begin
    shifted = {rem, quo[TIME_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    fits    = ~diff[TIME_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
        quo   <= {quo[TIME_W-2:0], fits};
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

/* sv/frame_index_sequencer.sv */
// ----------------------------------------------------------------------------
// frame_index_sequencer: picks the frame shown from a bounded cycle of frames
// Tick, set-index and next-frame items update the shown/requested frame.
// ----------------------------------------------------------------------------
// Sequence: set, next, frame-mode and pending-adopt ticks go from accept
//   straight to the emit state and the result register; an automatic
//   time-based tick first makes two passes through the one serial divider
//   (time / period, then slots mod cycle length) before the emit state.
// Throughput: one item at a time; req.ready is high only when idle. The
//   result register lets a new item in while the last result waits.
// Reset (rst, synchronous): frames and position go to 0, registers to their
//   defaults (period 1000, repeat 1, auto switch on), no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_index_sequencer
  import fis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  fis_req_if.sink                    req,
  fis_rsp_if.source                  rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_Q,   // time / period
    ST_DIV_R,   // slots mod cycle length
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [FRAME_W-1:0] frame;
  } place_t;

  // configuration
  logic [FRAME_W-1:0]  min_index;
  logic [FRAME_W-1:0]  max_index;
  logic [REPEAT_W-1:0] repeat_count;
  logic [TIME_W-1:0]   period_ticks;
  logic                auto_switch;
  logic                no_skip;
  logic                frame_mode;

  // sequencer state
  state_t              state;
  logic [FRAME_W-1:0]  shown_frame;
  logic [FRAME_W-1:0]  pending_frame;
  logic [POS_W-1:0]    sequence_position;
  logic                changed;

  // result register
  logic                out_valid;
  logic [FRAME_W-1:0]  out_shown;
  logic [FRAME_W-1:0]  out_requested;
  logic                out_changed;

  // divider hookup
  logic                div_start;
  logic [TIME_W-1:0]   div_a;
  logic [TIME_W-1:0]   div_b;
  logic                div_done;
  logic [TIME_W-1:0]   div_quo;
  logic [TIME_W-1:0]   div_rem;

  logic                accept;
  logic                auto_tick;  // accepted tick that needs the divider
  logic                emit;       // result register takes the item this cycle
  logic [TIME_W-1:0]   period_eff;
  logic [9:0]          limit;      // max_index + repeat_count
  logic [9:0]          cycle_len;
  logic [10:0]         slot;
  logic                slot_moved;
  logic [10:0]         step_pos;
  logic [10:0]         settle_in;
  place_t              settled;
  place_t              clamped;

  // Normalize a position: past the hold window wraps to min, inside the
  // hold window shows the last frame, otherwise the position is the frame.
  function automatic place_t settle(input logic [10:0] p,
                                    input logic [FRAME_W-1:0] mn,
                                    input logic [FRAME_W-1:0] mx,
                                    input logic [9:0] lim);
    place_t r;
    if (p > {3'b000, mx}) begin
      if (p >= {1'b0, lim}) begin
        r.pos   = {1'b0, mn};
        r.frame = clip_frame({3'b000, mn});
      end else begin
        r.pos   = p[POS_W-1:0];
        r.frame = clip_frame({3'b000, mx});
      end
    end else begin
      r.pos   = p[POS_W-1:0];
      r.frame = clip_frame(p);
    end
    return r;
  endfunction

  fis_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign accept  = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign auto_tick = accept && (req.func == FUNC_TICK) && (pending_frame == shown_frame) &&
                     auto_switch && !frame_mode;
  assign emit      = (state == ST_EMIT) && (!out_valid || rsp.ready);

  assign rsp.valid           = out_valid;
  assign rsp.shown_index     = out_shown;
  assign rsp.requested_index = out_requested;
  assign rsp.changed         = out_changed;

  always_comb begin
    period_eff = (period_ticks == '0) ? TIME_W'(1) : period_ticks;
    limit      = {2'b00, max_index} + {1'b0, repeat_count};
    // empty or negative cycle counts as length one
    if (limit <= {2'b00, min_index}) begin
      cycle_len = 10'd1;
    end else begin
      cycle_len = limit - {2'b00, min_index};
    end
    slot       = {1'b0, div_rem[9:0]} + {3'b000, min_index};
    slot_moved = (slot != {2'b00, sequence_position});
    step_pos   = {2'b00, sequence_position} + 11'd1;
    settle_in  = (state == ST_DIV_R && !no_skip) ? slot : step_pos;
    settled    = settle(settle_in, min_index, max_index, limit);

    // set-index clamp
    if (req.index_value < {1'b0, min_index}) begin
      clamped.pos   = {1'b0, min_index};
      clamped.frame = clip_frame({3'b000, min_index});
    end else if (req.index_value > {1'b0, max_index}) begin
      clamped.frame = clip_frame({3'b000, max_index});
      if ({1'b0, req.index_value} >= limit) begin
        if (repeat_count != '0) begin
          clamped.pos = POS_W'(limit - 10'd1);
        end else begin
          clamped.pos = {1'b0, max_index};
        end
      end else begin
        clamped.pos = req.index_value;
      end
    end else begin
      clamped.pos   = req.index_value;
      clamped.frame = clip_frame({2'b00, req.index_value});
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_index    <= '0;
      max_index    <= '0;
      repeat_count <= REPEAT_W'(1);
      period_ticks <= TIME_W'(1000);
      auto_switch  <= 1'b1;
      no_skip      <= 1'b0;
      frame_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_INDEX:    min_index    <= cfg_data[FRAME_W-1:0];
        REG_MAX_INDEX:    max_index    <= cfg_data[FRAME_W-1:0];
        REG_REPEAT_COUNT: repeat_count <= cfg_data[REPEAT_W-1:0];
        REG_PERIOD_TICKS: period_ticks <= cfg_data[TIME_W-1:0];
        REG_AUTO_SWITCH:  auto_switch  <= cfg_data[0];
        REG_NO_SKIP:      no_skip      <= cfg_data[0];
        REG_FRAME_MODE:   frame_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      shown_frame       <= '0;
      pending_frame     <= '0;
      sequence_position <= '0;
      changed           <= 1'b0;
      out_valid         <= 1'b0;
      div_start         <= 1'b0;
    end else begin
      // divider kicks off on an automatic tick and again for the modulo
      div_start <= auto_tick || (state == ST_DIV_Q && div_done);

      if (emit) begin
        out_valid     <= 1'b1;
        out_shown     <= shown_frame;
        out_requested <= pending_frame;
        out_changed   <= changed;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.func)
              FUNC_TICK: begin
                if (pending_frame != shown_frame) begin
                  // adopt the manual request first
                  shown_frame <= pending_frame;
                  changed     <= 1'b1;
                  state       <= ST_EMIT;
                end else if (auto_switch) begin
                  if (frame_mode) begin
                    changed           <= 1'b1;
                    sequence_position <= settled.pos;
                    pending_frame     <= settled.frame;
                    shown_frame       <= settled.frame;
                    state             <= ST_EMIT;
                  end else begin
                    changed <= 1'b0;
                    div_a   <= req.time_ticks;
                    div_b   <= period_eff;
                    state   <= ST_DIV_Q;
                  end
                end else begin
                  changed <= 1'b0;
                  state   <= ST_EMIT;
                end
              end
              FUNC_SET: begin
                sequence_position <= clamped.pos;
                pending_frame     <= clamped.frame;
                changed           <= 1'b0;
                state             <= ST_EMIT;
              end
              FUNC_NEXT: begin
                sequence_position <= settled.pos;
                pending_frame     <= settled.frame;
                changed           <= 1'b0;
                state             <= ST_EMIT;
              end
              default: begin
                changed <= 1'b0;
                state   <= ST_EMIT;
              end
            endcase
          end
        end

        ST_DIV_Q: begin
          if (div_done) begin
            div_a <= div_quo;
            div_b <= {{(TIME_W-10){1'b0}}, cycle_len};
            state <= ST_DIV_R;
          end
        end

        ST_DIV_R: begin
          if (div_done) begin
            if (slot_moved) begin
              changed           <= 1'b1;
              sequence_position <= settled.pos;
              pending_frame     <= settled.frame;
              shown_frame       <= settled.frame;
            end
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
